/* rtl/core/itam_pkg.sv */
// ----------------------------------------------------------------------------
// itam_pkg
// Types and constants shared by the ID-to-address multimatch table.
// ----------------------------------------------------------------------------
package itam_pkg;

    localparam int ITAM_TABLE_DEPTH  = 1024;
    localparam int ITAM_MATCH_LIMIT  = 4;
    localparam int ITAM_PREFIX_BYTES = 13;
    localparam int ITAM_EXACT_BYTES  = 15;
    localparam int ITAM_KEY_BYTES    = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR        = 2'd0,
        ACT_INSERT       = 2'd1,
        ACT_LOOKUP_ALL   = 2'd2,
        ACT_LOOKUP_EXACT = 2'd3
    } t_itam_action;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_FULL     = 2'd2
    } t_itam_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_itam_state;

    typedef struct packed {
        t_itam_action action;
        logic [63:0]  key_head;
        logic [63:0]  key_tail;
        logic [31:0]  entry_ip;
        logic [2:0]   max_matches;
    } t_itam_cmd;

    typedef struct packed {
        t_itam_status status;
        logic [31:0]  match_ip;
        logic [63:0]  match_key_head;
        logic [63:0]  match_key_tail;
        logic [2:0]   match_count;
        logic         last;
    } t_itam_result;

    typedef struct packed {
        logic [31:0] ip;
        logic [63:0] key_tail;
        logic [63:0] key_head;
    } t_itam_entry;

endpackage

/* rtl/core/itam_ram.sv */
// ----------------------------------------------------------------------------
// itam_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module itam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/itam_keycmp.sv */
// ----------------------------------------------------------------------------
// itam_keycmp
// String-rule key compare: bytes agree up to a shared zero byte or a fixed
// length. Gives the prefix-length and exact-length verdicts.
// ----------------------------------------------------------------------------
module itam_keycmp
    import itam_pkg::*;
(
    input  logic [63:0] i_query_head,
    input  logic [63:0] i_query_tail,
    input  logic [63:0] i_entry_head,
    input  logic [63:0] i_entry_tail,
    output logic        o_prefix_ok,
    output logic        o_exact_ok
);

    logic [8*ITAM_KEY_BYTES-1:0] query;
    logic [8*ITAM_KEY_BYTES-1:0] entry;
    logic [ITAM_KEY_BYTES-1:0]   byte_eq;
    logic [ITAM_KEY_BYTES-1:0]   zero_seen;
    logic [ITAM_KEY_BYTES-1:0]   byte_ok;

    assign query = {i_query_tail, i_query_head};
    assign entry = {i_entry_tail, i_entry_head};

    always_comb begin
        for (int i = 0; i < ITAM_KEY_BYTES; i++) begin
            byte_eq[i] = (query[8*i +: 8] == entry[8*i +: 8]);
        end
        zero_seen[0] = 1'b0;
        for (int i = 1; i < ITAM_KEY_BYTES; i++) begin
            zero_seen[i] = zero_seen[i-1] |
                           (byte_eq[i-1] & (query[8*(i-1) +: 8] == 8'h00));
        end
        for (int i = 0; i < ITAM_KEY_BYTES; i++) begin
            byte_ok[i] = byte_eq[i] | zero_seen[i];
        end
    end

    assign o_prefix_ok = &byte_ok[ITAM_PREFIX_BYTES-1:0];
    assign o_exact_ok  = &byte_ok[ITAM_EXACT_BYTES-1:0];

endmodule

/* rtl/core/id_to_address_multimatch_table_unit.sv */
// ----------------------------------------------------------------------------
// id_to_address_multimatch_table_unit
// Table of 16-byte text keys with 32-bit addresses, searched by key prefix or exact length.
// ----------------------------------------------------------------------------
// A command transfers when i_start is high and o_busy is low. Clear and
// insert answer with one result strobe in the cycle after the transfer and
// leave o_busy low. A lookup holds o_busy high while it reads the stored
// entries one per cycle from a single table RAM, in insertion order, and
// stops early once the match limit is reached; a lookup-all with a zero
// limit answers without a scan, as clear and insert do. Results come
// out on o_result while o_result_valid is high for one cycle each; the
// receiver cannot stall them, and the final result of a command has last
// set. Table contents are not cleared by reset or by clear; only the entry
// count is.
// ----------------------------------------------------------------------------
module id_to_address_multimatch_table_unit
    import itam_pkg::*;
#(
    parameter int TABLE_DEPTH = ITAM_TABLE_DEPTH,
    parameter int MATCH_LIMIT = ITAM_MATCH_LIMIT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_itam_cmd    i_cmd,
    output logic         o_busy,
    output logic         o_result_valid,
    output t_itam_result o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_itam_entry);
    localparam logic [2:0]    LIMIT_CAP = (MATCH_LIMIT > 7) ? 3'd7 : 3'(MATCH_LIMIT);
    localparam logic [CW-1:0] DEPTH_CW  = CW'(TABLE_DEPTH);

    t_itam_state  r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic          r_hv, n_hv;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_found, n_found;
    logic [2:0]    r_limit, n_limit;
    logic          r_exact, n_exact;
    logic [63:0]   r_qh, n_qh;
    logic [63:0]   r_qt, n_qt;
    t_itam_entry   r_hold, n_hold;
    t_itam_result  r_out, n_out;

    logic          accept;
    logic [2:0]    cmd_limit;
    logic          issue;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_itam_entry   ram_wdata;
    logic          ram_re;
    t_itam_entry   ram_rdata;
    logic          prefix_ok;
    logic          exact_ok;
    logic          hit;

    itam_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    itam_keycmp u_keycmp (
        .i_query_head (r_qh),
        .i_query_tail (r_qt),
        .i_entry_head (ram_rdata.key_head),
        .i_entry_tail (ram_rdata.key_tail),
        .o_prefix_ok  (prefix_ok),
        .o_exact_ok   (exact_ok)
    );

    assign accept    = i_start && (r_state == ST_IDLE);
    assign cmd_limit = (i_cmd.max_matches > LIMIT_CAP) ? LIMIT_CAP : i_cmd.max_matches;
    assign issue     = (r_state == ST_SCAN) && (r_idx < r_total);
    assign hit       = r_pend && prefix_ok && (!r_exact || exact_ok);

    assign ram_waddr      = r_total[AW-1:0];
    assign ram_wdata.ip       = i_cmd.entry_ip;
    assign ram_wdata.key_tail = i_cmd.key_tail;
    assign ram_wdata.key_head = i_cmd.key_head;
    assign ram_re         = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= '0;
            r_limit     <= '0;
            r_exact     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_hv        <= n_hv;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_limit     <= n_limit;
            r_exact     <= n_exact;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qh   <= n_qh;
        r_qt   <= n_qt;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_hv        = r_hv;
        n_found     = r_found;
        n_limit     = r_limit;
        n_exact     = r_exact;
        n_qh        = r_qh;
        n_qt        = r_qt;
        n_hold      = r_hold;
        n_out_valid = 1'b0;
        n_out       = '0;
        ram_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.action) inside
                        ACT_CLEAR: begin
                            n_total         = '0;
                            n_out_valid     = 1'b1;
                            n_out.status    = STAT_DONE;
                            n_out.last      = 1'b1;
                        end
                        ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            n_out.last  = 1'b1;
                            if (r_total < DEPTH_CW) begin
                                ram_we       = 1'b1;
                                n_total      = CW'(r_total + 1'b1);
                                n_out.status = STAT_DONE;
                            end else begin
                                n_out.status = STAT_FULL;
                            end
                        end
                        ACT_LOOKUP_ALL, ACT_LOOKUP_EXACT: begin
                            n_qh    = i_cmd.key_head;
                            n_qt    = i_cmd.key_tail;
                            n_exact = (i_cmd.action == ACT_LOOKUP_EXACT);
                            n_limit = (i_cmd.action == ACT_LOOKUP_EXACT) ? 3'd1 : cmd_limit;
                            n_idx   = '0;
                            n_found = '0;
                            n_hv    = 1'b0;
                            if ((i_cmd.action == ACT_LOOKUP_ALL) && (cmd_limit == 3'd0)) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STAT_NO_MATCH;
                                n_out.last   = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx  = CW'(r_idx + 1'b1);
                    n_pend = 1'b1;
                end
                if (hit) begin
                    if (r_hv) begin
                        n_out_valid          = 1'b1;
                        n_out.status         = STAT_DONE;
                        n_out.match_ip       = r_hold.ip;
                        n_out.match_key_head = r_hold.key_head;
                        n_out.match_key_tail = r_hold.key_tail;
                    end
                    n_hold  = ram_rdata;
                    n_hv    = 1'b1;
                    n_found = 3'(r_found + 3'd1);
                    if (3'(r_found + 3'd1) == r_limit) begin
                        n_state = ST_FINISH;
                    end
                end else if (!issue && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_out_valid = 1'b1;
                n_out.last  = 1'b1;
                if (r_hv) begin
                    n_out.status         = STAT_DONE;
                    n_out.match_ip       = r_hold.ip;
                    n_out.match_key_head = r_hold.key_head;
                    n_out.match_key_tail = r_hold.key_tail;
                    n_out.match_count    = r_found;
                end else begin
                    n_out.status = STAT_NO_MATCH;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ID-to-address multimatch table.
// ----------------------------------------------------------------------------
// Commands go in through the start/busy handshake and are mirrored into a
// scoreboard that keeps its own copy of the key table. From that copy it
// works out the result strobes each command must produce. Every strobe is
// checked field by field against the oldest pending answer.
//
// Stimulus runs in two phases:
//   - a directed pass over the corner cases: empty table, zero limit,
//     saturated limit, keys that end early, keys with no zero byte, and
//     lookups after a clear;
//   - a random pass built from a small pool of related keys, so that
//     prefix and exact matches are frequent.
// The sender idles at random, except during one quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import itam_pkg::*;

    localparam int KEY_W       = 8 * ITAM_KEY_BYTES;
    localparam int POOL_SIZE   = 6;
    localparam int RANDOM_CMDS = 346;
    localparam int CYCLE_LIMIT = 1000000;

    class lookup_scoreboard;
        logic [63:0]  key_heads [ITAM_TABLE_DEPTH];
        logic [63:0]  key_tails [ITAM_TABLE_DEPTH];
        logic [31:0]  addresses [ITAM_TABLE_DEPTH];
        int           entry_total;
        t_itam_result expected_answers [$];
        int           failures;

        function new();
            entry_total = 0;
            failures    = 0;
        endfunction

        function bit keys_agree(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b, int n);
            for (int i = 0; i < n; i++) begin
                if (a[8*i +: 8] != b[8*i +: 8])
                    return 1'b0;
                if (a[8*i +: 8] == 8'h00)
                    return 1'b1;
            end
            return 1'b1;
        endfunction

        function void predict_answers(t_itam_cmd cmd);
            t_itam_result     r;
            logic [KEY_W-1:0] query;
            logic [KEY_W-1:0] stored;
            int               limit;
            int               found;
            r        = '0;
            r.status = STAT_DONE;
            r.last   = 1'b1;
            query    = {cmd.key_tail, cmd.key_head};
            case (cmd.action)
                ACT_CLEAR: begin
                    entry_total = 0;
                    expected_answers.push_back(r);
                end
                ACT_INSERT: begin
                    if (entry_total < ITAM_TABLE_DEPTH) begin
                        key_heads[entry_total] = cmd.key_head;
                        key_tails[entry_total] = cmd.key_tail;
                        addresses[entry_total] = cmd.entry_ip;
                        entry_total++;
                    end else begin
                        r.status = STAT_FULL;
                    end
                    expected_answers.push_back(r);
                end
                ACT_LOOKUP_ALL: begin
                    limit = (cmd.max_matches > ITAM_MATCH_LIMIT) ? ITAM_MATCH_LIMIT
                                                                 : cmd.max_matches;
                    found = 0;
                    for (int i = 0; i < entry_total && found < limit; i++) begin
                        stored = {key_tails[i], key_heads[i]};
                        if (keys_agree(query, stored, ITAM_PREFIX_BYTES)) begin
                            r                = '0;
                            r.status         = STAT_DONE;
                            r.match_ip       = addresses[i];
                            r.match_key_head = key_heads[i];
                            r.match_key_tail = key_tails[i];
                            expected_answers.push_back(r);
                            found++;
                        end
                    end
                    if (found == 0) begin
                        r.status = STAT_NO_MATCH;
                        expected_answers.push_back(r);
                    end else begin
                        r             = expected_answers.pop_back();
                        r.match_count = 3'(found);
                        r.last        = 1'b1;
                        expected_answers.push_back(r);
                    end
                end
                default: begin
                    r.status = STAT_NO_MATCH;
                    for (int i = 0; i < entry_total; i++) begin
                        stored = {key_tails[i], key_heads[i]};
                        if (keys_agree(query, stored, ITAM_PREFIX_BYTES) &&
                            keys_agree(query, stored, ITAM_EXACT_BYTES)) begin
                            r.status         = STAT_DONE;
                            r.match_ip       = addresses[i];
                            r.match_key_head = key_heads[i];
                            r.match_key_tail = key_tails[i];
                            r.match_count    = 3'd1;
                            break;
                        end
                    end
                    expected_answers.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_answer(t_itam_result got);
            t_itam_result want;
            if (expected_answers.size() == 0) begin
                $error("result strobe with no pending answer: %0h", got);
                failures++;
                return;
            end
            want = expected_answers.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("match_ip", want.match_ip, got.match_ip);
            compare_field("match_key_head", want.match_key_head, got.match_key_head);
            compare_field("match_key_tail", want.match_key_tail, got.match_key_tail);
            compare_field("match_count", want.match_count, got.match_count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_start = 1'b0;
    t_itam_cmd    i_cmd   = '0;
    logic         o_busy;
    logic         o_result_valid;
    t_itam_result o_result;

    lookup_scoreboard board;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               no_gaps     = 1'b0;
    int unsigned      cycle_count = 0;

    id_to_address_multimatch_table_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_cmd          (i_cmd),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            board.check_answer(o_result);
        if (i_rst_n && i_start && !o_busy)
            board.predict_answers(i_cmd);
    end

    function automatic logic [KEY_W-1:0] base_key();
        logic [KEY_W-1:0] k;
        int               zpos;
        k = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(3))
            1, 2: begin
                zpos              = $urandom_range(15);
                k[8*zpos +: 8]    = 8'h00;
            end
            3: begin
                for (int i = 0; i < ITAM_KEY_BYTES; i++)
                    if (k[8*i +: 8] == 8'h00)
                        k[8*i +: 8] = 8'h80;
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] variant_key(logic [KEY_W-1:0] k);
        int zpos;
        int pos;
        case ($urandom_range(5))
            1: k[8*15 +: 8] = 8'($urandom);
            2: begin
                pos           = $urandom_range(13, 14);
                k[8*pos +: 8] = 8'($urandom);
            end
            3: begin
                zpos = ITAM_KEY_BYTES;
                for (int i = ITAM_KEY_BYTES - 1; i >= 0; i--)
                    if (k[8*i +: 8] == 8'h00)
                        zpos = i;
                for (int i = zpos + 1; i < ITAM_KEY_BYTES; i++)
                    k[8*i +: 8] = 8'($urandom);
            end
            4: begin
                pos           = $urandom_range(12);
                k[8*pos +: 8] = 8'($urandom);
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return variant_key(key_pool[$urandom_range(POOL_SIZE - 1)]);
        return base_key();
    endfunction

    // Present one command, hold it until it transfers, then maybe idle.
    task automatic send(input t_itam_action act, input logic [KEY_W-1:0] key,
                        input logic [31:0] ip, input logic [2:0] limit);
        t_itam_cmd cmd;
        int        gap;
        cmd.action      = act;
        cmd.key_head    = key[63:0];
        cmd.key_tail    = key[127:64];
        cmd.entry_ip    = ip;
        cmd.max_matches = limit;
        i_start <= 1'b1;
        i_cmd   <= cmd;
        do @(posedge i_clk); while (o_busy);
        if (!no_gaps && $urandom_range(99) < 20) begin
            gap     = $urandom_range(1, 2);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [KEY_W-1:0] k_alpha;
        logic [KEY_W-1:0] k_short;
        logic [KEY_W-1:0] k;
        t_itam_action     act;
        int               sel;

        board = new();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = base_key();
        k_alpha = 128'h7A79786D6C6B6A696867666564636261;
        k_short = 128'hF0E1D2C3B4A5968778695A4B3C006261;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ACT_CLEAR, '0, 32'h0, 3'd0);
        send(ACT_LOOKUP_ALL, '0, 32'h0, 3'd4);
        send(ACT_LOOKUP_EXACT, '1, 32'hFFFF_FFFF, 3'd7);
        send(ACT_INSERT, '0, 32'h0, 3'd0);
        send(ACT_INSERT, '1, 32'hFFFF_FFFF, 3'd7);
        send(ACT_INSERT, k_alpha, 32'h1, 3'd0);
        send(ACT_INSERT, {8'h41, k_alpha[119:0]}, 32'h2, 3'd0);
        send(ACT_INSERT, {k_alpha[127:120], 8'h42, k_alpha[111:0]}, 32'h3, 3'd0);
        send(ACT_INSERT, {k_alpha[127:112], 8'h43, k_alpha[103:0]}, 32'h4, 3'd0);
        send(ACT_INSERT, k_short, 32'h5, 3'd0);
        send(ACT_INSERT, k_alpha, 32'h6, 3'd0);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd0);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd1);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd4);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd7);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd3);
        send(ACT_LOOKUP_EXACT, {8'h55, k_alpha[119:0]}, 32'h0, 3'd0);
        send(ACT_LOOKUP_EXACT, {k_alpha[127:120], 8'h55, k_alpha[111:0]}, 32'h0, 3'd0);
        send(ACT_LOOKUP_ALL, 128'h0102030405060708090A0B0C0D006261, 32'h0, 3'd4);
        send(ACT_LOOKUP_EXACT, 128'h0123456789ABCDEF0123456789ABCD00, 32'h0, 3'd1);
        send(ACT_LOOKUP_ALL, '1, 32'h0, 3'd2);
        send(ACT_CLEAR, '1, 32'hFFFF_FFFF, 3'd7);
        send(ACT_LOOKUP_ALL, k_alpha, 32'h0, 3'd4);
        send(ACT_LOOKUP_EXACT, k_alpha, 32'h0, 3'd4);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            no_gaps = (n >= 150 && n < 230);
            sel     = $urandom_range(99);
            if (sel < 3 || (board.entry_total > 40 && sel < 12))
                act = ACT_CLEAR;
            else if (sel < 45)
                act = ACT_INSERT;
            else if (sel < 75)
                act = ACT_LOOKUP_ALL;
            else
                act = ACT_LOOKUP_EXACT;
            if (act == ACT_CLEAR)
                key_pool[$urandom_range(POOL_SIZE - 1)] = base_key();
            k = pick_key((act == ACT_INSERT) ? 70 : 80);
            send(act, k, $urandom, 3'($urandom_range(7)));
        end
        no_gaps = 1'b0;
        i_start <= 1'b0;

        @(posedge i_clk);
        while (board.expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (board.failures == 0 && board.expected_answers.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
